FILE: rtl/smc_pkg.sv
// Shared constants, types and codes of the sphere-map to cube-map texel sampler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package smc_pkg;

    localparam int MAX_SOURCE_EDGE = 512;
    localparam int MAX_CUBE_EDGE   = 512;

    localparam int IDX_W    = 9;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int RGBA_W   = 32;

    localparam int Q_W      = 18;
    localparam int DIVR_W   = 18;
    localparam int DIVD_W   = 35;
    localparam int SQ_W     = 34;
    localparam int RT_W     = 35;
    localparam int SQ_STEPS = 17;
    localparam int LEN_W    = 17;
    localparam int DIR_W    = 18;
    localparam int WGT_W    = 9;
    localparam int PX_W     = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_EDGE     = 2'd2;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;

    localparam logic        CMD_LOAD   = 1'b0;
    localparam logic        CMD_SAMPLE = 1'b1;

    localparam logic signed [DIR_W-1:0] DIR_ONE = 18'sd65536;
    localparam logic [LEN_W-1:0]        Q16_ONE = 17'd65536;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        lcol;
        logic [IDX_W-1:0]        lrow;
        logic [RGBA_W-1:0]       rgba;
        logic [2:0]              face;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dz;
    } t_carry;

    typedef struct packed {
        logic              sample;
        logic [IDX_W-1:0]  lcol;
        logic [IDX_W-1:0]  lrow;
        logic [RGBA_W-1:0] rgba;
        logic [IDX_W-1:0]  xa;
        logic [IDX_W-1:0]  xb;
        logic [IDX_W-1:0]  ya;
        logic [IDX_W-1:0]  yb;
        logic [WGT_W-1:0]  fx;
        logic [WGT_W-1:0]  fy;
    } t_fetch;

    typedef logic [3:0][RGBA_W-1:0] t_quad;

endpackage

`default_nettype wire

FILE: rtl/smc_div.sv
// Pipelined restoring divider, two dividends over one shared divisor, one quotient bit a stage.
// Carries a side record along; depends on smc_pkg.
`default_nettype none

module smc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [smc_pkg::DIVD_W-1:0]    i_num_a,
    input  wire logic [smc_pkg::DIVD_W-1:0]    i_num_b,
    input  wire logic [smc_pkg::DIVR_W-1:0]    i_den,
    input  wire smc_pkg::t_carry               i_cry,
    output logic                               o_vld,
    output logic [smc_pkg::Q_W-1:0]            o_quo_a,
    output logic [smc_pkg::Q_W-1:0]            o_quo_b,
    output smc_pkg::t_carry                    o_cry
);

    localparam int QW = smc_pkg::Q_W;
    localparam int RW = smc_pkg::DIVR_W;

    function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic nb,
                                             input logic [RW-1:0] den);
        logic [RW:0] trial;
        logic [RW:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[RW-1:0]};
        end
        return {1'b0, trial[RW-1:0]};
    endfunction

    logic            r_vld   [QW];
    logic [RW-1:0]   r_rem_a [QW];
    logic [RW-1:0]   r_rem_b [QW];
    logic [QW-1:0]   r_low_a [QW];
    logic [QW-1:0]   r_low_b [QW];
    logic [QW-1:0]   r_quo_a [QW];
    logic [QW-1:0]   r_quo_b [QW];
    logic [RW-1:0]   r_den   [QW];
    smc_pkg::t_carry r_cry   [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic            w_vld;
        logic [RW-1:0]   w_rem_a, w_rem_b, w_den;
        logic [QW-1:0]   w_low_a, w_low_b, w_quo_a, w_quo_b;
        smc_pkg::t_carry w_cry;
        logic [RW:0]     w_step_a, w_step_b;

        if (g == 0) begin : g_head
            assign w_vld   = i_vld;
            assign w_rem_a = RW'(i_num_a[smc_pkg::DIVD_W-1:QW]);
            assign w_rem_b = RW'(i_num_b[smc_pkg::DIVD_W-1:QW]);
            assign w_low_a = i_num_a[QW-1:0];
            assign w_low_b = i_num_b[QW-1:0];
            assign w_quo_a = '0;
            assign w_quo_b = '0;
            assign w_den   = i_den;
            assign w_cry   = i_cry;
        end else begin : g_body
            assign w_vld   = r_vld[g-1];
            assign w_rem_a = r_rem_a[g-1];
            assign w_rem_b = r_rem_b[g-1];
            assign w_low_a = r_low_a[g-1];
            assign w_low_b = r_low_b[g-1];
            assign w_quo_a = r_quo_a[g-1];
            assign w_quo_b = r_quo_b[g-1];
            assign w_den   = r_den[g-1];
            assign w_cry   = r_cry[g-1];
        end

        assign w_step_a = div_step(w_rem_a, w_low_a[QW-1], w_den);
        assign w_step_b = div_step(w_rem_b, w_low_b[QW-1], w_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a[g] <= w_step_a[RW-1:0];
                r_rem_b[g] <= w_step_b[RW-1:0];
                r_quo_a[g] <= {w_quo_a[QW-2:0], w_step_a[RW]};
                r_quo_b[g] <= {w_quo_b[QW-2:0], w_step_b[RW]};
                r_low_a[g] <= {w_low_a[QW-2:0], 1'b0};
                r_low_b[g] <= {w_low_b[QW-2:0], 1'b0};
                r_den[g]   <= w_den;
                r_cry[g]   <= w_cry;
            end
        end
    end

    assign o_vld   = r_vld[QW-1];
    assign o_quo_a = r_quo_a[QW-1];
    assign o_quo_b = r_quo_b[QW-1];
    assign o_cry   = r_cry[QW-1];

endmodule

`default_nettype wire

FILE: rtl/smc_sqrt.sv
// Pipelined integer square root, one root bit a stage, floor result.
// Carries a side record along; depends on smc_pkg.
`default_nettype none

module smc_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire logic [smc_pkg::SQ_W-1:0]    i_rad,
    input  wire smc_pkg::t_carry             i_cry,
    output logic                             o_vld,
    output logic [smc_pkg::LEN_W-1:0]        o_root,
    output smc_pkg::t_carry                  o_cry
);

    localparam int NS = smc_pkg::SQ_STEPS;
    localparam int RW = smc_pkg::RT_W;

    logic            r_vld  [NS];
    logic [RW-1:0]   r_rem  [NS];
    logic [RW-1:0]   r_root [NS];
    smc_pkg::t_carry r_cry  [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam logic [RW-1:0] STEP_BIT = RW'(1) << (2 * (NS - 1 - g));
        logic            w_vld;
        logic [RW-1:0]   w_rem, w_root, w_sum;
        smc_pkg::t_carry w_cry;

        if (g == 0) begin : g_head
            assign w_vld  = i_vld;
            assign w_rem  = RW'(i_rad);
            assign w_root = '0;
            assign w_cry  = i_cry;
        end else begin : g_body
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_cry  = r_cry[g-1];
        end

        assign w_sum = w_root + STEP_BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem >= w_sum) begin
                    r_rem[g]  <= w_rem - w_sum;
                    r_root[g] <= (w_root >> 1) + STEP_BIT;
                end else begin
                    r_rem[g]  <= w_rem;
                    r_root[g] <= w_root >> 1;
                end
                r_cry[g] <= w_cry;
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_root[NS-1][smc_pkg::LEN_W-1:0];
    assign o_cry  = r_cry[NS-1];

endmodule

`default_nettype wire

FILE: rtl/smc_fetch.sv
// Source texel store: single-port synchronous memory, one write per load request,
// four sequential reads per sample request. Depends on smc_pkg.
`default_nettype none

module smc_fetch (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire smc_pkg::t_fetch             i_item,
    input  wire logic                        i_back,
    output logic                             o_rdy,
    output logic                             o_vld,
    output smc_pkg::t_quad                   o_tex,
    output logic [smc_pkg::WGT_W-1:0]        o_fx,
    output logic [smc_pkg::WGT_W-1:0]        o_fy
);

    localparam int DEPTH = 1 << smc_pkg::ADDR_W;
    localparam logic [1:0] LAST_SLOT = 2'd3;
    localparam logic [1:0] FIRST_SLOT = 2'd0;

    logic [smc_pkg::RGBA_W-1:0] r_store [DEPTH];
    smc_pkg::t_quad             r_tex;
    smc_pkg::t_fetch            r_item;
    logic                       r_busy;
    logic                       r_done;
    logic [1:0]                 r_phase;

    logic                        w_acc;
    logic                        w_we;
    logic                        w_re;
    logic [1:0]                  w_ph;
    logic [smc_pkg::ADDR_W-1:0]  w_addr;
    smc_pkg::t_fetch             w_cur;

    assign o_rdy = !r_busy && (!r_done || i_back);
    assign w_acc = i_vld && o_rdy;
    assign w_cur = r_busy ? r_item : i_item;
    assign w_ph  = r_busy ? r_phase : FIRST_SLOT;

    always_comb begin
        w_we   = 1'b0;
        w_re   = 1'b0;
        w_addr = {w_ph[1] ? w_cur.yb : w_cur.ya, w_ph[0] ? w_cur.xb : w_cur.xa};
        if (r_busy) begin
            w_re = 1'b1;
        end else if (w_acc) begin
            if (i_item.sample) begin
                w_re = 1'b1;
            end else begin
                w_we   = 1'b1;
                w_addr = {i_item.lrow, i_item.lcol};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_addr] <= i_item.rgba;
        end else if (w_re) begin
            r_tex[w_ph] <= r_store[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= FIRST_SLOT;
        end else begin
            if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == LAST_SLOT) begin
                    r_busy <= 1'b0;
                end
            end else if (w_acc && i_item.sample) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd1;
            end
            if (r_busy && r_phase == LAST_SLOT) begin
                r_done <= 1'b1;
            end else if (i_back) begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_vld = r_done;
    assign o_tex = r_tex;
    assign o_fx  = r_item.fx;
    assign o_fy  = r_item.fy;

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("fetch result pending while reads in flight");

    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> !r_busy)
        else $error("request taken while store port busy");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == LAST_SLOT) |=> (r_done && !r_busy))
        else $error("fourth read did not complete the sample");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_back) |=> r_done)
        else $error("fetched texels dropped under stall");

endmodule

`default_nettype wire

FILE: rtl/smc_filter.sv
// Bilinear blend of four RGBA8 texels with 9-bit weights (0 to 256), round half up, clamp,
// followed by the output register. Depends on smc_pkg.
`default_nettype none

module smc_filter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire smc_pkg::t_quad              i_tex,
    input  wire logic [smc_pkg::WGT_W-1:0]   i_fx,
    input  wire logic [smc_pkg::WGT_W-1:0]   i_fy,
    input  wire logic                        i_rdy,
    output logic                             o_back,
    output logic                             o_vld,
    output logic [smc_pkg::RGBA_W-1:0]       o_rgba
);

    localparam logic [smc_pkg::WGT_W-1:0] W_FULL = 9'd256;

    logic                        r_f1_vld;
    logic [15:0]                 r_top [4];
    logic [15:0]                 r_bot [4];
    logic [smc_pkg::WGT_W-1:0]   r_fy;
    logic                        r_out_vld;
    logic [smc_pkg::RGBA_W-1:0]  r_rgba;

    logic [16:0]                 n_top [4];
    logic [16:0]                 n_bot [4];
    logic [smc_pkg::RGBA_W-1:0]  n_rgba;
    logic [smc_pkg::WGT_W-1:0]   w_gx;
    logic [smc_pkg::WGT_W-1:0]   w_gy;
    logic [24:0]                 w_acc [4];

    assign o_back = !r_out_vld || i_rdy;
    assign w_gx   = W_FULL - i_fx;
    assign w_gy   = W_FULL - r_fy;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_top[c] = i_tex[0][8*c +: 8] * w_gx + i_tex[1][8*c +: 8] * i_fx;
            n_bot[c] = i_tex[2][8*c +: 8] * w_gx + i_tex[3][8*c +: 8] * i_fx;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_acc[c] = r_top[c] * w_gy + r_bot[c] * r_fy + 25'd32768;
            n_rgba[8*c +: 8] = (w_acc[c][24:16] > 9'd255) ? 8'd255 : w_acc[c][23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (o_back) begin
            r_f1_vld  <= i_vld;
            r_out_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_back) begin
            for (int c = 0; c < 4; c++) begin
                r_top[c] <= n_top[c][15:0];
                r_bot[c] <= n_bot[c][15:0];
            end
            r_fy   <= i_fy;
            r_rgba <= n_rgba;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_rgba = r_rgba;

endmodule

`default_nettype wire

FILE: rtl/sphere_map_cube_texel_sampler.sv
// Sphere-map to cube-map texel sampler, top level: configuration registers, face
// geometry stages, and the divider, root, store and filter units. Depends on smc_pkg.
//
// A load request writes one RGBA8 texel into a 512x512 store with one write of the
// store port; a sample request maps a cube texel to the sphere map and
// returns one bilinearly filtered RGBA8 result. A sample holds the single-port
// store for one read per corner texel and takes no new request until its reads are
// done. Loads flow at one per cycle and all other stages accept a request every
// cycle while the store and the output do not stall. A sample passes two 18-stage
// dividers, a 17-stage root, the four-read fetch and the blend. Requests
// leave in order, so a load never overtakes or falls behind a sample. The store has
// no reset or clearing pass: a sample must only touch texels that were loaded.
// Write configuration only while no request is in flight.
`default_nettype none

module sphere_map_cube_texel_sampler (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // load_col[8:0], load_row[17:9], load_rgba[49:18], face_index[52:50],
    // cube_col[61:53], cube_row[70:62], zero pad [71]
    input  wire logic [71:0]                      i_s_tdata,
    // cmd
    input  wire logic                             i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [31:0]                           o_m_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [smc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [smc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CW = smc_pkg::CFG_W;
    localparam int IW = smc_pkg::IDX_W;

    function automatic logic [CW-1:0] eff_size(input logic [CW-1:0] v, input int maxv);
        if (v == '0) begin
            return CW'(1);
        end
        if (v > CW'(maxv)) begin
            return CW'(maxv);
        end
        return v;
    endfunction

    function automatic logic [IW-1:0] clamp_idx(input logic [10:0] v, input logic [CW-1:0] lim);
        if (v > {1'b0, lim}) begin
            return lim[IW-1:0];
        end
        return v[IW-1:0];
    endfunction

    logic [CW-1:0] r_cfg_w, r_cfg_h, r_cfg_n;
    logic [CW-1:0] w_w, w_h, w_n, w_wm1, w_hm1, w_nm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CW'(512);
            r_cfg_h <= CW'(512);
            r_cfg_n <= CW'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smc_pkg::CFG_SOURCE_WIDTH:  r_cfg_w <= i_cfg_data;
                smc_pkg::CFG_SOURCE_HEIGHT: r_cfg_h <= i_cfg_data;
                smc_pkg::CFG_CUBE_EDGE:     r_cfg_n <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_w   = eff_size(r_cfg_w, smc_pkg::MAX_SOURCE_EDGE);
    assign w_h   = eff_size(r_cfg_h, smc_pkg::MAX_SOURCE_EDGE);
    assign w_n   = eff_size(r_cfg_n, smc_pkg::MAX_CUBE_EDGE);
    assign w_wm1 = w_w - CW'(1);
    assign w_hm1 = w_h - CW'(1);
    assign w_nm1 = w_n - CW'(1);

    logic w_front;
    logic w_fetch_rdy;
    logic w_back;

    // input stage
    logic            r_p0_vld;
    smc_pkg::t_carry r_p0;
    logic [IW-1:0]   r_p0_col, r_p0_row;
    smc_pkg::t_carry n_p0;
    logic [IW-1:0]   n_p0_col, n_p0_row;

    always_comb begin
        n_p0.kind = i_s_tuser;
        n_p0.lcol = i_s_tdata[8:0];
        n_p0.lrow = i_s_tdata[17:9];
        n_p0.rgba = i_s_tdata[49:18];
        n_p0.face = i_s_tdata[52:50];
        n_p0.dx   = '0;
        n_p0.dz   = '0;
        n_p0_col  = clamp_idx({2'b00, i_s_tdata[61:53]}, w_nm1);
        n_p0_row  = clamp_idx({2'b00, i_s_tdata[70:62]}, w_nm1);
    end

    assign o_s_tready = w_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else if (w_front) begin
            r_p0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_front) begin
            r_p0     <= n_p0;
            r_p0_col <= n_p0_col;
            r_p0_row <= n_p0_row;
        end
    end

    // texel centres: q = ((2c+1)*2^17 + n) / 2n
    logic                         w_d1_vld;
    logic [smc_pkg::Q_W-1:0]      w_q_s, w_q_t;
    smc_pkg::t_carry              w_d1_cry;

    smc_div u_div_st (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_front),
        .i_vld   (r_p0_vld),
        .i_num_a (smc_pkg::DIVD_W'({r_p0_col, 1'b1, 17'd0}) + smc_pkg::DIVD_W'(w_n)),
        .i_num_b (smc_pkg::DIVD_W'({r_p0_row, 1'b1, 17'd0}) + smc_pkg::DIVD_W'(w_n)),
        .i_den   (smc_pkg::DIVR_W'({w_n, 1'b0})),
        .i_cry   (r_p0),
        .o_vld   (w_d1_vld),
        .o_quo_a (w_q_s),
        .o_quo_b (w_q_t),
        .o_cry   (w_d1_cry)
    );

    // face direction and squares
    logic [18:0]                     w_s_full, w_t_full;
    logic signed [smc_pkg::DIR_W-1:0] w_s, w_t, w_dx, w_dy, w_dz;
    logic signed [35:0]              w_px, w_py, w_pz;
    logic                            r_p1_vld;
    smc_pkg::t_carry                 r_p1;
    logic [smc_pkg::SQ_W-1:0]        r_sqx, r_sqy, r_sqz;
    smc_pkg::t_carry                 n_p1;

    assign w_s_full = {1'b0, w_q_s} - 19'd65536;
    assign w_t_full = {1'b0, w_q_t} - 19'd65536;
    assign w_s = $signed(w_s_full[17:0]);
    assign w_t = $signed(w_t_full[17:0]);

    always_comb begin
        unique case (w_d1_cry.face)
            smc_pkg::FACE_POS_X: begin
                w_dx = smc_pkg::DIR_ONE;  w_dy = -w_t; w_dz = -w_s;
            end
            smc_pkg::FACE_NEG_X: begin
                w_dx = -smc_pkg::DIR_ONE; w_dy = -w_t; w_dz = w_s;
            end
            smc_pkg::FACE_POS_Y: begin
                w_dx = w_s; w_dy = smc_pkg::DIR_ONE;  w_dz = w_t;
            end
            smc_pkg::FACE_NEG_Y: begin
                w_dx = w_s; w_dy = -smc_pkg::DIR_ONE; w_dz = -w_t;
            end
            smc_pkg::FACE_POS_Z: begin
                w_dx = w_s; w_dy = -w_t; w_dz = smc_pkg::DIR_ONE;
            end
            default: begin
                w_dx = -w_s; w_dy = -w_t; w_dz = -smc_pkg::DIR_ONE;
            end
        endcase
        n_p1    = w_d1_cry;
        n_p1.dx = w_dx;
        n_p1.dz = w_dz;
    end

    assign w_px = w_dx * w_dx;
    assign w_py = w_dy * w_dy;
    assign w_pz = w_dz * w_dz;

    logic                     r_p2_vld;
    smc_pkg::t_carry          r_p2;
    logic [smc_pkg::SQ_W-1:0] r_p2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else if (w_front) begin
            r_p1_vld <= w_d1_vld;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_front) begin
            r_p1     <= n_p1;
            r_sqx    <= w_px[smc_pkg::SQ_W-1:0];
            r_sqy    <= w_py[smc_pkg::SQ_W-1:0];
            r_sqz    <= w_pz[smc_pkg::SQ_W-1:0];
            r_p2     <= r_p1;
            r_p2_sum <= r_sqx + r_sqy + r_sqz;
        end
    end

    // vector length
    logic                        w_sq_vld;
    logic [smc_pkg::LEN_W-1:0]   w_len;
    smc_pkg::t_carry             w_sq_cry;

    smc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_front),
        .i_vld   (r_p2_vld),
        .i_rad   (r_p2_sum),
        .i_cry   (r_p2),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_cry   (w_sq_cry)
    );

    // u = (len+dx)/(2 len), v = (len-dz)/(2 len), rounded half up
    logic signed [18:0] w_ua, w_va;

    assign w_ua = $signed({2'b00, w_len}) + 19'(w_sq_cry.dx);
    assign w_va = $signed({2'b00, w_len}) - 19'(w_sq_cry.dz);

    logic                     w_d2_vld;
    logic [smc_pkg::Q_W-1:0]  w_q_u, w_q_v;
    smc_pkg::t_carry          w_d2_cry;

    smc_div u_div_uv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_front),
        .i_vld   (w_sq_vld),
        .i_num_a (smc_pkg::DIVD_W'({w_ua[17:0], 16'd0}) + smc_pkg::DIVD_W'(w_len)),
        .i_num_b (smc_pkg::DIVD_W'({w_va[17:0], 16'd0}) + smc_pkg::DIVD_W'(w_len)),
        .i_den   (smc_pkg::DIVR_W'({w_len, 1'b0})),
        .i_cry   (w_sq_cry),
        .o_vld   (w_d2_vld),
        .o_quo_a (w_q_u),
        .o_quo_b (w_q_v),
        .o_cry   (w_d2_cry)
    );

    // source position, 16 fractional bits, offset by half a texel
    logic [smc_pkg::LEN_W-1:0] w_uq, w_vq;
    logic [smc_pkg::PX_W-1:0]  w_pxm, w_pym;
    logic                      r_p3_vld;
    smc_pkg::t_carry           r_p3;
    logic [smc_pkg::PX_W-1:0]  r_p3_px, r_p3_py;

    assign w_uq  = (w_q_u > smc_pkg::Q_W'(smc_pkg::Q16_ONE)) ? smc_pkg::Q16_ONE
                                                              : w_q_u[smc_pkg::LEN_W-1:0];
    assign w_vq  = (w_q_v > smc_pkg::Q_W'(smc_pkg::Q16_ONE)) ? smc_pkg::Q16_ONE
                                                              : w_q_v[smc_pkg::LEN_W-1:0];
    assign w_pxm = w_uq * w_w;
    assign w_pym = w_vq * w_h;

    // texel indices and weights
    logic [10:0]              w_hx, w_hy;
    logic [16:0]              w_frx, w_fry;
    smc_pkg::t_fetch          n_p4;
    logic                     r_p4_vld;
    smc_pkg::t_fetch          r_p4;

    assign w_hx  = r_p3_px[26:16];
    assign w_hy  = r_p3_py[26:16];
    assign w_frx = {1'b0, r_p3_px[15:0]} + 17'd128;
    assign w_fry = {1'b0, r_p3_py[15:0]} + 17'd128;

    always_comb begin
        n_p4.sample = (r_p3.kind == smc_pkg::CMD_SAMPLE);
        n_p4.lcol   = r_p3.lcol;
        n_p4.lrow   = r_p3.lrow;
        n_p4.rgba   = r_p3.rgba;
        n_p4.xa     = (w_hx == '0) ? '0 : clamp_idx(w_hx - 11'd1, w_wm1);
        n_p4.xb     = clamp_idx(w_hx, w_wm1);
        n_p4.ya     = (w_hy == '0) ? '0 : clamp_idx(w_hy - 11'd1, w_hm1);
        n_p4.yb     = clamp_idx(w_hy, w_hm1);
        n_p4.fx     = w_frx[16:8];
        n_p4.fy     = w_fry[16:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else if (w_front) begin
            r_p3_vld <= w_d2_vld;
            r_p4_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_front) begin
            r_p3    <= w_d2_cry;
            r_p3_px <= w_pxm + smc_pkg::PX_W'(32768);
            r_p3_py <= w_pym + smc_pkg::PX_W'(32768);
            r_p4    <= n_p4;
        end
    end

    assign w_front = !r_p4_vld || w_fetch_rdy;

    // store and blend
    logic                         w_f_vld;
    smc_pkg::t_quad               w_f_tex;
    logic [smc_pkg::WGT_W-1:0]    w_f_fx, w_f_fy;

    smc_fetch u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p4_vld),
        .i_item  (r_p4),
        .i_back  (w_back),
        .o_rdy   (w_fetch_rdy),
        .o_vld   (w_f_vld),
        .o_tex   (w_f_tex),
        .o_fx    (w_f_fx),
        .o_fy    (w_f_fy)
    );

    smc_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_f_vld),
        .i_tex   (w_f_tex),
        .i_fx    (w_f_fx),
        .i_fy    (w_f_fy),
        .i_rdy   (i_m_tready),
        .o_back  (w_back),
        .o_vld   (o_m_tvalid),
        .o_rgba  (o_m_tdata)
    );

endmodule

`default_nettype wire
